// ----- src/sctir_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sctir_pkg
// Types and constants shared by the sound chip timer and interrupt registers.
// ----------------------------------------------------------------------------
package sctir_pkg;

    localparam int COUNT_W  = 26;
    localparam int RELOAD_W = 24;

    typedef logic signed [COUNT_W-1:0] count_t;
    typedef logic [RELOAD_W-1:0]       reload_t;
    typedef logic [7:0]                byte_t;

    localparam count_t COUNT_FLOOR = count_t'(-64'sd8388608);

    // commands
    localparam logic [2:0] CMD_WRITE      = 3'd0;
    localparam logic [2:0] CMD_READ       = 3'd1;
    localparam logic [2:0] CMD_TICK       = 3'd2;
    localparam logic [2:0] CMD_ARM_SERIN  = 3'd3;
    localparam logic [2:0] CMD_ARM_SEROUT = 3'd4;

    // register offsets
    localparam logic [3:0] ADDR_FREQ1    = 4'd0;
    localparam logic [3:0] ADDR_FREQ2    = 4'd2;
    localparam logic [3:0] ADDR_FREQ3    = 4'd4;
    localparam logic [3:0] ADDR_FREQ4    = 4'd6;
    localparam logic [3:0] ADDR_CTRL     = 4'd8;
    localparam logic [3:0] ADDR_RESTART  = 4'd9;
    localparam logic [3:0] ADDR_KEYCODE  = 4'd9;
    localparam logic [3:0] ADDR_SEROUT   = 4'd13;
    localparam logic [3:0] ADDR_IRQ      = 4'd14;
    localparam logic [3:0] ADDR_SERCTL   = 4'd15;
    localparam logic [3:0] ADDR_KEYFLAGS = 4'd15;

    // audio control bits
    localparam int CTRL_SLOW   = 0;
    localparam int CTRL_JOIN34 = 3;
    localparam int CTRL_JOIN12 = 4;
    localparam int CTRL_FAST3  = 5;
    localparam int CTRL_FAST1  = 6;

    // interrupt bits
    localparam int IRQ_XMTDONE = 3;
    localparam int IRQ_SEROUT  = 4;
    localparam int IRQ_SERIN   = 5;

    localparam byte_t      IRQ_CLEAR_MASK = 8'hf7;
    localparam logic [2:0] SERCTL_TX_MODE = 3'd2;
    localparam byte_t      SEROUT_FREQ3   = 8'h28;
    localparam byte_t      SEROUT_FREQ4   = 8'h00;
    localparam byte_t      READ_IDLE      = 8'hff;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] addr;
        byte_t      wdata;
        byte_t      key_code;
        logic       shift_held;
        logic       key_pressed;
    } in_item_t;

    typedef struct packed {
        byte_t rdata;
        logic  irq_line;
        logic  tx_valid;
        byte_t tx_byte;
    } out_item_t;

endpackage
`default_nettype wire

// ----- src/sctir_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sctir_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface sctir_in_if;
    logic                 valid;
    logic                 ready;
    sctir_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sctir_out_if;
    logic                 valid;
    logic                 ready;
    sctir_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/sctir_reload.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sctir_reload
// Reload values of timers 1, 2 and 4 from frequency bytes and audio control.
// ----------------------------------------------------------------------------
module sctir_reload #(
    parameter int LINE_CYCLES = 114,
    parameter int BASE64_DIV  = 28,
    parameter int BASE15_DIV  = 114
) (
    input  wire logic [3:0][7:0]   freq,
    input  wire sctir_pkg::byte_t  ctrl,
    output sctir_pkg::reload_t     reload [3]
);

    localparam sctir_pkg::reload_t LINE_R = sctir_pkg::reload_t'(LINE_CYCLES);

    logic [7:0]  base;
    logic [8:0]  f1_inc;
    logic [16:0] f1_prod;
    sctir_pkg::reload_t r1;

    function automatic sctir_pkg::reload_t at_least_line(input sctir_pkg::reload_t r);
        return (r < LINE_R) ? LINE_R : r;
    endfunction

    function automatic sctir_pkg::reload_t pair_reload(input logic [7:0] lo,
                                                       input logic [7:0] hi,
                                                       input logic joined,
                                                       input logic fast,
                                                       input logic [7:0] b);
        logic [16:0] word;
        logic [8:0]  hi_inc;
        logic [24:0] prod;
        sctir_pkg::reload_t r;
        word   = {1'b0, hi, lo} + 17'd1;
        hi_inc = {1'b0, hi} + 9'd1;
        if (joined)
        begin
            if (fast)
            begin
                r = sctir_pkg::reload_t'({hi, lo}) + sctir_pkg::reload_t'(7);
            end
            else
            begin
                prod = word * b;
                r = prod[sctir_pkg::RELOAD_W-1:0];
            end
        end
        else
        begin
            prod = 25'(hi_inc * b);
            r = prod[sctir_pkg::RELOAD_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        base    = ctrl[sctir_pkg::CTRL_SLOW] ? 8'(BASE15_DIV) : 8'(BASE64_DIV);
        f1_inc  = {1'b0, freq[0]} + 9'd1;
        f1_prod = f1_inc * base;
        if (ctrl[sctir_pkg::CTRL_FAST1])
        begin
            r1 = sctir_pkg::reload_t'(freq[0]) + sctir_pkg::reload_t'(4);
        end
        else
        begin
            r1 = sctir_pkg::reload_t'(f1_prod);
        end
        reload[0] = at_least_line(r1);
        reload[1] = at_least_line(pair_reload(freq[0], freq[1],
                                              ctrl[sctir_pkg::CTRL_JOIN12],
                                              ctrl[sctir_pkg::CTRL_FAST1], base));
        reload[2] = at_least_line(pair_reload(freq[2], freq[3],
                                              ctrl[sctir_pkg::CTRL_JOIN34],
                                              ctrl[sctir_pkg::CTRL_FAST3], base));
    end

endmodule
`default_nettype wire

// ----- src/sctir_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sctir_timer
// One line of countdown for a timer: underflow detect, reload and floor.
// ----------------------------------------------------------------------------
module sctir_timer #(
    parameter int LINE_CYCLES = 114
) (
    input  wire sctir_pkg::count_t  count,
    input  wire sctir_pkg::reload_t reload,
    output sctir_pkg::count_t       count_next,
    output logic                    underflow
);

    localparam sctir_pkg::count_t LINE_C = sctir_pkg::count_t'(LINE_CYCLES);

    sctir_pkg::count_t dec;
    sctir_pkg::count_t sum;

    always_comb
    begin
        dec       = count - LINE_C;
        underflow = dec[sctir_pkg::COUNT_W-1];
        sum       = underflow ? dec + $signed({1'b0, reload}) : dec;
        count_next = (sum < sctir_pkg::COUNT_FLOOR) ? sctir_pkg::COUNT_FLOOR : sum;
    end

endmodule
`default_nettype wire

// ----- src/sctir_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sctir_regs
// Register file and command decode; state advances on each committed command.
// ----------------------------------------------------------------------------
module sctir_regs #(
    parameter int LINE_CYCLES   = 114,
    parameter int BASE64_DIV    = 28,
    parameter int BASE15_DIV    = 114,
    parameter int XMTDONE_LINES = 15
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 commit,
    input  wire sctir_pkg::in_item_t  item,
    output sctir_pkg::out_item_t      result
);

    logic [3:0][7:0]    freq_reg, freq_next;
    sctir_pkg::byte_t   ctrl_reg, ctrl_next;
    sctir_pkg::byte_t   status_reg, status_next;
    sctir_pkg::byte_t   enable_reg, enable_next;
    sctir_pkg::byte_t   serctl_reg, serctl_next;
    sctir_pkg::byte_t   serin_reg, serin_next;
    sctir_pkg::byte_t   serout_reg, serout_next;
    sctir_pkg::byte_t   xmt_reg, xmt_next;
    logic               level_reg, level_next;
    sctir_pkg::count_t  count_reg [3];
    sctir_pkg::count_t  count_next [3];
    sctir_pkg::reload_t reload_reg [3];
    sctir_pkg::reload_t reload_next [3];
    sctir_pkg::reload_t reload_calc [3];
    sctir_pkg::count_t  count_tick [3];
    logic [2:0]         underflow;
    logic [2:0]         reload_upd;

    logic is_write;
    logic wr_f1, wr_f2, wr_f3, wr_f4, wr_ctrl;

    assign is_write = (item.cmd == sctir_pkg::CMD_WRITE);
    assign wr_f1    = is_write && (item.addr == sctir_pkg::ADDR_FREQ1);
    assign wr_f2    = is_write && (item.addr == sctir_pkg::ADDR_FREQ2);
    assign wr_f3    = is_write && (item.addr == sctir_pkg::ADDR_FREQ3);
    assign wr_f4    = is_write && (item.addr == sctir_pkg::ADDR_FREQ4);
    assign wr_ctrl  = is_write && (item.addr == sctir_pkg::ADDR_CTRL);

    // bytes as they stand after this command
    always_comb
    begin
        freq_next = freq_reg;
        if (wr_f1)
        begin
            freq_next[0] = item.wdata;
        end
        if (wr_f2)
        begin
            freq_next[1] = item.wdata;
        end
        if (wr_f3)
        begin
            freq_next[2] = item.wdata;
        end
        if (wr_f4)
        begin
            freq_next[3] = item.wdata;
        end
        ctrl_next = wr_ctrl ? item.wdata : ctrl_reg;
    end

    sctir_reload #(
        .LINE_CYCLES (LINE_CYCLES),
        .BASE64_DIV  (BASE64_DIV),
        .BASE15_DIV  (BASE15_DIV)
    ) u_reload (
        .freq   (freq_next),
        .ctrl   (ctrl_next),
        .reload (reload_calc)
    );

    assign reload_upd[0] = wr_f1 || wr_ctrl;
    assign reload_upd[1] = (wr_f1 && ctrl_reg[sctir_pkg::CTRL_JOIN12]) || wr_f2 || wr_ctrl;
    assign reload_upd[2] = (wr_f3 && ctrl_reg[sctir_pkg::CTRL_JOIN34]) || wr_f4 || wr_ctrl;

    for (genvar i = 0; i < 3; i++)
    begin : g_timer
        sctir_timer #(
            .LINE_CYCLES (LINE_CYCLES)
        ) u_timer (
            .count      (count_reg[i]),
            .reload     (reload_reg[i]),
            .count_next (count_tick[i]),
            .underflow  (underflow[i])
        );

        assign reload_next[i] = reload_upd[i] ? reload_calc[i] : reload_reg[i];
    end

    always_comb
    begin
        status_next = status_reg;
        enable_next = enable_reg;
        serctl_next = serctl_reg;
        serin_next  = serin_reg;
        serout_next = serout_reg;
        xmt_next    = xmt_reg;
        level_next  = level_reg;
        for (int i = 0; i < 3; i++)
        begin
            count_next[i] = count_reg[i];
        end
        result.rdata    = sctir_pkg::READ_IDLE;
        result.tx_valid = 1'b0;
        result.tx_byte  = 8'h00;

        case (item.cmd)
            sctir_pkg::CMD_WRITE:
            begin
                case (item.addr)
                    sctir_pkg::ADDR_RESTART:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            count_next[i] = '0;
                        end
                    end
                    sctir_pkg::ADDR_SEROUT:
                    begin
                        if (serctl_reg[6:4] == sctir_pkg::SERCTL_TX_MODE &&
                            freq_reg[2] == sctir_pkg::SEROUT_FREQ3 &&
                            freq_reg[3] == sctir_pkg::SEROUT_FREQ4 &&
                            ctrl_reg[sctir_pkg::CTRL_FAST3] &&
                            ctrl_reg[sctir_pkg::CTRL_JOIN34])
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = item.wdata;
                            status_next[sctir_pkg::IRQ_XMTDONE] = 1'b1;
                            xmt_next = 8'(XMTDONE_LINES);
                        end
                    end
                    sctir_pkg::ADDR_IRQ:
                    begin
                        enable_next = item.wdata;
                        status_next = status_reg | (~item.wdata & sctir_pkg::IRQ_CLEAR_MASK);
                        if ((~status_next & item.wdata) == 8'h00)
                        begin
                            level_next = 1'b0;
                        end
                    end
                    sctir_pkg::ADDR_SERCTL:
                    begin
                        serctl_next = item.wdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sctir_pkg::CMD_READ:
            begin
                case (item.addr)
                    sctir_pkg::ADDR_KEYCODE:
                    begin
                        result.rdata = item.key_code;
                    end
                    sctir_pkg::ADDR_IRQ:
                    begin
                        result.rdata = status_reg;
                    end
                    sctir_pkg::ADDR_KEYFLAGS:
                    begin
                        result.rdata[3] = ~item.shift_held;
                        result.rdata[2] = ~item.key_pressed;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sctir_pkg::CMD_TICK:
            begin
                if (serin_reg != 8'h00)
                begin
                    serin_next = serin_reg - 8'd1;
                    if (serin_next == 8'h00 && enable_reg[sctir_pkg::IRQ_SERIN])
                    begin
                        status_next[sctir_pkg::IRQ_SERIN] = 1'b0;
                        level_next = 1'b1;
                    end
                end
                if (serout_reg != 8'h00)
                begin
                    serout_next = serout_reg - 8'd1;
                    if (serout_next == 8'h00 && enable_reg[sctir_pkg::IRQ_SEROUT])
                    begin
                        status_next[sctir_pkg::IRQ_SEROUT] = 1'b0;
                        level_next = 1'b1;
                    end
                end
                if (xmt_reg != 8'h00)
                begin
                    xmt_next = xmt_reg - 8'd1;
                    if (xmt_next == 8'h00)
                    begin
                        status_next[sctir_pkg::IRQ_XMTDONE] = 1'b0;
                        if (enable_reg[sctir_pkg::IRQ_XMTDONE])
                        begin
                            level_next = 1'b1;
                        end
                    end
                end
                // timer slots map to status bits 0, 1 and 2
                for (int i = 0; i < 3; i++)
                begin
                    count_next[i] = count_tick[i];
                    if (underflow[i] && enable_reg[i])
                    begin
                        status_next[i] = 1'b0;
                        level_next = 1'b1;
                    end
                end
            end
            sctir_pkg::CMD_ARM_SERIN:
            begin
                serin_next = item.wdata;
            end
            sctir_pkg::CMD_ARM_SEROUT:
            begin
                serout_next = item.wdata;
            end
            default:
            begin
            end
        endcase

        result.irq_line = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= '0;
            ctrl_reg   <= '0;
            status_reg <= 8'hff;
            enable_reg <= '0;
            serctl_reg <= '0;
            serin_reg  <= '0;
            serout_reg <= '0;
            xmt_reg    <= '0;
            level_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            freq_reg   <= freq_next;
            ctrl_reg   <= ctrl_next;
            status_reg <= status_next;
            enable_reg <= enable_next;
            serctl_reg <= serctl_next;
            serin_reg  <= serin_next;
            serout_reg <= serout_next;
            xmt_reg    <= xmt_next;
            level_reg  <= level_next;
            for (int i = 0; i < 3; i++)
            begin
                count_reg[i]  <= count_next[i];
                reload_reg[i] <= reload_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/sound_chip_timer_irq_registers_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sound_chip_timer_irq_registers_core
// Timer and interrupt registers of a sound and I/O chip, one command per
// transaction.
//
// in_ch carries one command (write, read, scanline tick, arm serin or serout
// delay) per transaction; out_ch returns exactly one result per command:
// read byte, interrupt line level, and any serial byte sent.
// A command is captured in an input register, decoded and applied to the
// register file when it moves on to the output register, which holds its
// result and drives out_ch.valid. Throughput is one command per cycle,
// set by the single decode stage between the input and output registers,
// as long as out_ch does not stall.
// When out_ch stalls, the output register holds its result and the input
// register holds one more command; in_ch then drops ready until the output
// is taken. Reset clears all control and register state, with the interrupt
// status reading 0xff and the interrupt line low.
// ----------------------------------------------------------------------------
module sound_chip_timer_irq_registers_core #(
    parameter int LINE_CYCLES   = 114,
    parameter int BASE64_DIV    = 28,
    parameter int BASE15_DIV    = 114,
    parameter int XMTDONE_LINES = 15
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sctir_in_if.sink    in_ch,
    sctir_out_if.source out_ch
);

    logic                 stg_valid_reg, stg_valid_next;
    sctir_pkg::in_item_t  stg_item_reg;
    logic                 out_valid_reg, out_valid_next;
    sctir_pkg::out_item_t out_item_reg;
    sctir_pkg::out_item_t result;
    logic                 advance;
    logic                 in_take;

    assign advance     = stg_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !stg_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    sctir_regs #(
        .LINE_CYCLES   (LINE_CYCLES),
        .BASE64_DIV    (BASE64_DIV),
        .BASE15_DIV    (BASE15_DIV),
        .XMTDONE_LINES (XMTDONE_LINES)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (stg_item_reg),
        .result (result)
    );

    always_comb
    begin
        stg_valid_next = in_take || (stg_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_item_reg <= in_ch.payload;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

endmodule
`default_nettype wire

// ----- bench/sound_chip_timer_irq_registers_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_chip_timer_irq_registers_core_tb
// Self-checking bench for the timer and interrupt register block.
//
// A queue of commands feeds a valid/ready driver. Every accepted transaction
// is run through a cycle-free model of the registers, the three timers and
// the serial delays. The expected result is queued and matched in order
// against each result taken from the output channel. Both sides idle at
// random. The run starts from reset with corner cases and a run of ticks
// while the reloads are still zero, then the all-ones frequency bytes, and
// then random command sequences with serial setup, delay arming and enable toggles.
// ----------------------------------------------------------------------------
module sound_chip_timer_irq_registers_core_tb;
    import sctir_pkg::*;

    localparam int LINE_CYCLES    = 114;
    localparam int BASE64_DIV     = 28;
    localparam int BASE15_DIV     = 114;
    localparam int XMTDONE_LINES  = 15;

    localparam int ZERO_TICKS     = 120;
    localparam int RAND_ITEMS     = 1100;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int KEYFLAG_SHIFT  = 3;
    localparam int KEYFLAG_KEY    = 2;
    localparam logic [2:0] CMD_LAST = CMD_ARM_SEROUT;

    typedef struct {
        in_item_t item;
        bit       drain_first;
        bit       hold_rx;
    } stim_t;

    logic clk;
    logic rst_n;

    sctir_in_if  cmd_ch ();
    sctir_out_if res_ch ();

    sound_chip_timer_irq_registers_core #(
        .LINE_CYCLES   (LINE_CYCLES),
        .BASE64_DIV    (BASE64_DIV),
        .BASE15_DIV    (BASE15_DIV),
        .XMTDONE_LINES (XMTDONE_LINES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    // register file model
    byte_t   fq [4];
    byte_t   actl;
    byte_t   irq_st;
    byte_t   irq_en;
    byte_t   serctl;
    count_t  tcount [3];
    reload_t treload [3];
    bit      slow_sel;
    byte_t   serin_dly;
    byte_t   serout_dly;
    byte_t   xmt_dly;
    bit      irq_lvl;

    stim_t     command_q [$];
    out_item_t pending_results [$];

    bit in_taken    = 1'b0;
    bit rx_hold_req = 1'b0;
    int send_gap    = 0;
    int tx_quiet    = 0;
    int rx_quiet    = 0;
    int rx_stall    = 0;
    int rx_hold     = 0;
    int cycles      = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_tx        = 0;
    int n_irq_high  = 0;
    int n_errors    = 0;

    function automatic reload_t calc_reload(int slot);
        int  base;
        int  r;
        int  lo;
        int  hi;
        bit  joined;
        bit  fast;
        base = slow_sel ? BASE15_DIV : BASE64_DIV;
        if (slot == 0)
        begin
            r = actl[CTRL_FAST1] ? int'(fq[0]) + 4 : (int'(fq[0]) + 1) * base;
        end
        else
        begin
            lo     = (slot == 1) ? int'(fq[0]) : int'(fq[2]);
            hi     = (slot == 1) ? int'(fq[1]) : int'(fq[3]);
            joined = (slot == 1) ? actl[CTRL_JOIN12] : actl[CTRL_JOIN34];
            fast   = (slot == 1) ? actl[CTRL_FAST1] : actl[CTRL_FAST3];
            if (joined)
                r = fast ? hi * 256 + lo + 7 : (hi * 256 + lo + 1) * base;
            else
                r = (hi + 1) * base;
        end
        if (r < LINE_CYCLES)
            r = LINE_CYCLES;
        return reload_t'(r);
    endfunction

    function automatic void tick_slot(int slot);
        count_t c;
        c = tcount[slot] - count_t'(LINE_CYCLES);
        if (c < 0)
        begin
            c = c + count_t'(treload[slot]);
            if (irq_en[slot])
            begin
                irq_st[slot] = 1'b0;
                irq_lvl      = 1'b1;
            end
        end
        if (c < COUNT_FLOOR)
            c = COUNT_FLOOR;
        tcount[slot] = c;
    endfunction

    function automatic out_item_t run_command(in_item_t it);
        out_item_t res;
        res.rdata    = READ_IDLE;
        res.irq_line = 1'b0;
        res.tx_valid = 1'b0;
        res.tx_byte  = '0;
        case (it.cmd)
            CMD_WRITE:
            begin
                case (it.addr)
                    ADDR_FREQ1:
                    begin
                        fq[0]      = it.wdata;
                        treload[0] = calc_reload(0);
                        if (actl[CTRL_JOIN12])
                            treload[1] = calc_reload(1);
                    end
                    ADDR_FREQ2:
                    begin
                        fq[1]      = it.wdata;
                        treload[1] = calc_reload(1);
                    end
                    ADDR_FREQ3:
                    begin
                        fq[2] = it.wdata;
                        if (actl[CTRL_JOIN34])
                            treload[2] = calc_reload(2);
                    end
                    ADDR_FREQ4:
                    begin
                        fq[3]      = it.wdata;
                        treload[2] = calc_reload(2);
                    end
                    ADDR_CTRL:
                    begin
                        actl     = it.wdata;
                        slow_sel = it.wdata[CTRL_SLOW];
                        for (int k = 0; k < 3; k++)
                            treload[k] = calc_reload(k);
                    end
                    ADDR_RESTART:
                    begin
                        for (int k = 0; k < 3; k++)
                            tcount[k] = '0;
                    end
                    ADDR_SEROUT:
                    begin
                        if (serctl[6:4] == SERCTL_TX_MODE && fq[2] == SEROUT_FREQ3 &&
                            fq[3] == SEROUT_FREQ4 && actl[CTRL_FAST3] &&
                            actl[CTRL_JOIN34])
                        begin
                            res.tx_valid        = 1'b1;
                            res.tx_byte         = it.wdata;
                            irq_st[IRQ_XMTDONE] = 1'b1;
                            xmt_dly             = byte_t'(XMTDONE_LINES);
                        end
                    end
                    ADDR_IRQ:
                    begin
                        irq_en = it.wdata;
                        irq_st = irq_st | (~it.wdata & IRQ_CLEAR_MASK);
                        if (byte_t'(~irq_st & irq_en) == 8'h00)
                            irq_lvl = 1'b0;
                    end
                    ADDR_SERCTL: serctl = it.wdata;
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (it.addr)
                    ADDR_KEYCODE: res.rdata = it.key_code;
                    ADDR_IRQ:     res.rdata = irq_st;
                    ADDR_KEYFLAGS:
                    begin
                        if (it.shift_held)
                            res.rdata[KEYFLAG_SHIFT] = 1'b0;
                        if (it.key_pressed)
                            res.rdata[KEYFLAG_KEY] = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_TICK:
            begin
                if (serin_dly > 0)
                begin
                    serin_dly--;
                    if (serin_dly == 0 && irq_en[IRQ_SERIN])
                    begin
                        irq_st[IRQ_SERIN] = 1'b0;
                        irq_lvl           = 1'b1;
                    end
                end
                if (serout_dly > 0)
                begin
                    serout_dly--;
                    if (serout_dly == 0 && irq_en[IRQ_SEROUT])
                    begin
                        irq_st[IRQ_SEROUT] = 1'b0;
                        irq_lvl            = 1'b1;
                    end
                end
                if (xmt_dly > 0)
                begin
                    xmt_dly--;
                    if (xmt_dly == 0)
                    begin
                        irq_st[IRQ_XMTDONE] = 1'b0;
                        if (irq_en[IRQ_XMTDONE])
                            irq_lvl = 1'b1;
                    end
                end
                for (int k = 0; k < 3; k++)
                    tick_slot(k);
            end
            CMD_ARM_SERIN:  serin_dly  = it.wdata;
            CMD_ARM_SEROUT: serout_dly = it.wdata;
            default: ;
        endcase
        res.irq_line = irq_lvl;
        return res;
    endfunction

    function automatic int next_gap(ref int quiet);
        int pick;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0)
            quiet = 60;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_cmd(logic [2:0] cmd, logic [3:0] addr, byte_t wdata,
                                     bit drain = 1'b0, bit hold = 1'b0);
        in_item_t it;
        it.cmd         = cmd;
        it.addr        = addr;
        it.wdata       = wdata;
        it.key_code    = byte_t'($urandom);
        it.shift_held  = 1'($urandom);
        it.key_pressed = 1'($urandom);
        command_q.push_back('{item: it, drain_first: drain, hold_rx: hold});
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // command driver
    always @(negedge clk)
    begin
        stim_t s;
        if (rst_n && (!cmd_ch.valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (command_q.size() > 0 &&
                     !(command_q[0].drain_first && pending_results.size() > 0))
            begin
                s = command_q.pop_front();
                cmd_ch.payload <= s.item;
                cmd_ch.valid   <= 1'b1;
                if (s.hold_rx)
                begin
                    rx_hold_req = 1'b1;
                    tx_quiet    = 100;
                end
                send_gap = next_gap(tx_quiet);
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold     = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                res_ch.ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    rx_stall = next_gap(rx_quiet);
            end
        end
    end

    // transaction monitor and scoreboard
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            in_taken = rst_n && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1;
            if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got = res_ch.payload;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing expected, rdata %h",
                                              got.rdata));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.rdata !== want.rdata)
                        report_mismatch($sformatf("result %0d rdata %h, expected %h",
                                                  n_checked, got.rdata, want.rdata));
                    if (got.irq_line !== want.irq_line)
                        report_mismatch($sformatf("result %0d irq_line %b, expected %b",
                                                  n_checked, got.irq_line, want.irq_line));
                    if (got.tx_valid !== want.tx_valid)
                        report_mismatch($sformatf("result %0d tx_valid %b, expected %b",
                                                  n_checked, got.tx_valid, want.tx_valid));
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch($sformatf("result %0d tx_byte %h, expected %h",
                                                  n_checked, got.tx_byte, want.tx_byte));
                    if (want.tx_valid)
                        n_tx++;
                    if (want.irq_line)
                        n_irq_high++;
                    n_checked++;
                end
            end
            if (in_taken)
            begin
                pending_results.push_back(run_command(cmd_ch.payload));
                n_sent++;
            end
        end
    end

    initial
    begin
        in_item_t it;
        byte_t    d;
        int       base_n;
        int       sel;
        int       which;
        bit       broken;
        bit       hold_done;
        bit       drain_done;

        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;

        for (int k = 0; k < 4; k++)
            fq[k] = '0;
        for (int k = 0; k < 3; k++)
        begin
            tcount[k]  = '0;
            treload[k] = '0;
        end
        actl       = '0;
        irq_st     = 8'hff;
        irq_en     = '0;
        serctl     = '0;
        slow_sel   = 1'b0;
        serin_dly  = '0;
        serout_dly = '0;
        xmt_dly    = '0;
        irq_lvl    = 1'b0;

        // corner cases from reset, reloads still zero
        push_cmd(CMD_READ, ADDR_IRQ, 8'h00);
        it = '{cmd: CMD_READ, addr: ADDR_KEYCODE, wdata: 8'hff, key_code: 8'h00,
               shift_held: 1'b0, key_pressed: 1'b0};
        command_q.push_back('{item: it, drain_first: 1'b0, hold_rx: 1'b0});
        it.key_code = 8'hff;
        command_q.push_back('{item: it, drain_first: 1'b0, hold_rx: 1'b0});
        it.addr = ADDR_KEYFLAGS;
        command_q.push_back('{item: it, drain_first: 1'b0, hold_rx: 1'b0});
        it.shift_held  = 1'b1;
        it.key_pressed = 1'b1;
        command_q.push_back('{item: it, drain_first: 1'b0, hold_rx: 1'b0});
        push_cmd(CMD_READ, ADDR_FREQ1, 8'h00);
        for (int a = 0; a < 16; a++)
        begin
            case (4'(a))
                ADDR_FREQ1, ADDR_FREQ2, ADDR_FREQ3, ADDR_FREQ4, ADDR_CTRL,
                ADDR_RESTART, ADDR_SEROUT, ADDR_IRQ, ADDR_SERCTL: ;
                default: push_cmd(CMD_WRITE, 4'(a), 8'hff);
            endcase
        end
        for (int k = CMD_LAST + 1; k < 8; k++)
            push_cmd(3'(k), 4'($urandom), byte_t'($urandom));
        push_cmd(CMD_WRITE, ADDR_SEROUT, 8'h5a);
        push_cmd(CMD_WRITE, ADDR_IRQ, 8'h07);
        push_cmd(CMD_TICK, ADDR_FREQ1, 8'h00);

        // tick run with zero reloads, every tick underflows and counts keep falling
        for (int n = 0; n < ZERO_TICKS; n++)
        begin
            if (n % 40 == 0)
            begin
                push_cmd(CMD_WRITE, ADDR_IRQ, 8'h00);
                push_cmd(CMD_WRITE, ADDR_IRQ, 8'h07);
                push_cmd(CMD_READ, ADDR_IRQ, 8'h00);
            end
            push_cmd(CMD_TICK, 4'($urandom), byte_t'($urandom));
        end

        // all-ones frequency bytes, all control bits set
        push_cmd(CMD_WRITE, ADDR_CTRL, 8'hff);
        push_cmd(CMD_WRITE, ADDR_FREQ1, 8'hff);
        push_cmd(CMD_WRITE, ADDR_FREQ2, 8'hff);
        push_cmd(CMD_WRITE, ADDR_FREQ3, 8'hff);
        push_cmd(CMD_WRITE, ADDR_FREQ4, 8'hff);
        push_cmd(CMD_TICK, ADDR_FREQ1, 8'h00);
        push_cmd(CMD_READ, ADDR_IRQ, 8'h00);
        push_cmd(CMD_WRITE, ADDR_RESTART, 8'h00);
        push_cmd(CMD_WRITE, ADDR_CTRL, 8'h00);

        // random sequences; first one waits for an empty pipeline
        push_cmd(CMD_READ, ADDR_IRQ, 8'h00, 1'b1);
        base_n     = command_q.size();
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (command_q.size() - base_n < RAND_ITEMS)
        begin
            if (!hold_done && command_q.size() - base_n > 400)
            begin
                hold_done = 1'b1;
                push_cmd(CMD_READ, ADDR_IRQ, 8'h00, 1'b0, 1'b1);
            end
            if (!drain_done && command_q.size() - base_n > 900)
            begin
                drain_done = 1'b1;
                push_cmd(CMD_READ, ADDR_IRQ, 8'h00, 1'b1);
            end
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                repeat ($urandom_range(1, 12))
                    push_cmd(CMD_TICK, 4'($urandom), byte_t'($urandom));
            end
            else if (sel < 45)
            begin
                push_cmd(CMD_READ, 4'($urandom), byte_t'($urandom));
            end
            else if (sel < 62)
            begin
                d = ($urandom_range(0, 3) == 0) ? byte_t'($urandom)
                                                : byte_t'($urandom_range(0, 12));
                push_cmd(CMD_WRITE, 4'($urandom), d);
            end
            else if (sel < 74)
            begin
                push_cmd(CMD_WRITE, ADDR_IRQ,
                         ($urandom_range(0, 1) == 0) ? 8'h00 : byte_t'($urandom));
                push_cmd(CMD_WRITE, ADDR_IRQ, byte_t'($urandom));
            end
            else if (sel < 84)
            begin
                // serial out setup, sometimes with one condition broken
                broken = ($urandom_range(0, 3) == 0);
                which  = $urandom_range(0, 3);
                d = byte_t'($urandom);
                d[6:4] = (broken && which == 0) ? 3'($urandom) : SERCTL_TX_MODE;
                push_cmd(CMD_WRITE, ADDR_SERCTL, d);
                push_cmd(CMD_WRITE, ADDR_FREQ3,
                         (broken && which == 1) ? byte_t'($urandom) : SEROUT_FREQ3);
                push_cmd(CMD_WRITE, ADDR_FREQ4,
                         (broken && which == 2) ? byte_t'($urandom) : SEROUT_FREQ4);
                d = byte_t'($urandom);
                d[CTRL_FAST3]  = 1'b1;
                d[CTRL_JOIN34] = (broken && which == 3) ? 1'($urandom) : 1'b1;
                push_cmd(CMD_WRITE, ADDR_CTRL, d);
                push_cmd(CMD_WRITE, ADDR_IRQ, byte_t'($urandom));
                repeat ($urandom_range(1, 2))
                    push_cmd(CMD_WRITE, ADDR_SEROUT, byte_t'($urandom));
                repeat ($urandom_range(10, 20))
                    push_cmd(CMD_TICK, 4'($urandom), byte_t'($urandom));
                push_cmd(CMD_READ, ADDR_IRQ, 8'h00);
            end
            else if (sel < 92)
            begin
                d = ($urandom_range(0, 4) == 0) ? byte_t'($urandom)
                                                : byte_t'($urandom_range(0, 20));
                push_cmd(($urandom_range(0, 1) == 0) ? CMD_ARM_SERIN : CMD_ARM_SEROUT,
                         4'($urandom), d);
                repeat ($urandom_range(0, 25))
                    push_cmd(CMD_TICK, 4'($urandom), byte_t'($urandom));
            end
            else if (sel < 96)
            begin
                push_cmd(CMD_WRITE, ADDR_RESTART, byte_t'($urandom));
            end
            else
            begin
                push_cmd(3'($urandom_range(CMD_LAST + 1, 7)), 4'($urandom),
                         byte_t'($urandom));
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (command_q.size() > 0 || cmd_ch.valid || pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d commands, checked %0d results in %0d cycles",
                 n_sent, n_checked, cycles);
        $display("serial bytes sent %0d, results with interrupt line high %0d",
                 n_tx, n_irq_high);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
